// ===== sv/assert_macros.svh =====
// Assertion helpers used by the RTL controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SM3_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`define SM3_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define SM3_ASSERT(lbl, clk, rst_n, prop, msg)

`define SM3_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== sv/sm3_pkg.sv =====
`timescale 1ns / 1ps

package sm3_pkg;

  typedef logic [31:0] word_t;
  typedef logic [2:0]  bcount_t;
  typedef logic [63:0] blen_t;

  localparam word_t SM3_IV [8] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  localparam word_t   T_LOW     = 32'h79CC4519;
  localparam word_t   T_HIGH    = 32'h7A879D8A;
  localparam word_t   PAD_WORD  = 32'h80000000;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam bcount_t FULL_WORD = 3'd4;

  // source of the word shifted into the block window
  typedef enum logic [2:0] {
    SEL_IN,
    SEL_TAIL,
    SEL_PAD80,
    SEL_ZERO,
    SEL_LEN_HI,
    SEL_LEN_LO
  } word_sel_t;

  typedef struct packed {
    logic      push;
    word_sel_t sel;
    logic      add_len;
    logic      clr_len;
    logic      load;
    logic      round;
    logic      early;
    logic      t_switch;
    logic      fold;
    logic      out_shift;
    logic [2:0] out_idx;
  } dp_cmd_t;

  function automatic word_t rotl(word_t x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic word_t perm0(word_t x);
    return x ^ rotl(x, 9) ^ rotl(x, 17);
  endfunction

  function automatic word_t perm1(word_t x);
    return x ^ rotl(x, 15) ^ rotl(x, 23);
  endfunction

  // bytes the beat adds to the message; only a last beat may be short
  function automatic bcount_t eff_count(bcount_t bc, logic last);
    if (!last || bc > FULL_WORD) begin
      return FULL_WORD;
    end
    return bc;
  endfunction

  // short last word: keep the valid bytes, append the 0x80 marker
  function automatic word_t tail_word(word_t w, bcount_t cnt);
    word_t res;
    unique case (cnt)
      3'd0:    res = PAD_WORD;
      3'd1:    res = {w[31:24], PAD_BYTE, 16'h0000};
      3'd2:    res = {w[31:16], PAD_BYTE, 8'h00};
      3'd3:    res = {w[31:8], PAD_BYTE};
      default: res = w;
    endcase
    return res;
  endfunction

endpackage

// ===== sv/sm3_if.sv =====
`timescale 1ns / 1ps

interface sm3_in_if import sm3_pkg::*; ();
  logic    valid;
  logic    ready;
  word_t   message_word;
  bcount_t byte_count;
  logic    is_last;

  modport source(output valid, output message_word, output byte_count, output is_last,
                 input ready);
  modport sink(input valid, input message_word, input byte_count, input is_last,
               output ready);
endinterface

interface sm3_out_if import sm3_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t digest_word;
  logic  digest_last;

  modport source(output valid, output digest_word, output digest_last, input ready);
  modport sink(input valid, input digest_word, input digest_last, output ready);
endinterface

// ===== sv/sm3_hash_engine.sv =====
`timescale 1ns / 1ps

// SM3 hash engine. Message beats are 32-bit big-endian words; the beat marked
// is_last carries 0..4 valid bytes (left aligned) and the engine appends the
// 0x80 marker, zero fill and 64-bit bit length itself, then returns the 256-bit
// digest as eight beats, word 0 first, digest_last on the eighth. A beat that
// completes a 16-word block starts a compression on the single shared round
// unit, one round at a time, and no input is taken until it finishes. After
// the last beat the engine pushes the padding words up to the block end and
// compresses each padded block (one or two), then sends the eight digest
// beats; no input is taken until the digest has been delivered.

module sm3_hash_engine import sm3_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sm3_in_if.sink     in_bus,
  sm3_out_if.source  out_bus
);

  dp_cmd_t cmd;

  sm3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_count  (in_bus.byte_count),
    .in_last   (in_bus.is_last),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_last  (out_bus.digest_last),
    .out_ready (out_bus.ready),
    .cmd       (cmd)
  );

  sm3_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_word     (in_bus.message_word),
    .in_count    (in_bus.byte_count),
    .in_last     (in_bus.is_last),
    .digest_word (out_bus.digest_word)
  );

endmodule

// ===== sv/sm3_datapath.sv =====
`timescale 1ns / 1ps

module sm3_datapath import sm3_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  dp_cmd_t cmd,
  input  word_t   in_word,
  input  bcount_t in_count,
  input  logic    in_last,
  output word_t   digest_word
);

  word_t   win_r   [16];
  word_t   reg_r   [8];
  word_t   reg_nxt [8];
  word_t   chain_r [8];
  word_t   tj_r;
  blen_t   blen_r;

  bcount_t cnt;
  word_t   push_word;
  word_t   w_exp;
  word_t   a12, ss1, ss2, ff, gg, tt1, tt2;

  assign cnt = eff_count(in_count, in_last);

  always_comb begin
    unique case (cmd.sel)
      SEL_IN:     push_word = in_word;
      SEL_TAIL:   push_word = tail_word(in_word, cnt);
      SEL_PAD80:  push_word = PAD_WORD;
      SEL_ZERO:   push_word = '0;
      SEL_LEN_HI: push_word = blen_r[63:32];
      SEL_LEN_LO: push_word = blen_r[31:0];
      default:    push_word = '0;
    endcase
  end

  // window holds W[j..j+15]; next expanded word W[j+16]
  assign w_exp = perm1(win_r[0] ^ win_r[7] ^ rotl(win_r[13], 15))
                 ^ rotl(win_r[3], 7) ^ win_r[10];

  always_comb begin
    a12 = rotl(reg_r[0], 12);
    ss1 = rotl(a12 + reg_r[4] + tj_r, 7);
    ss2 = ss1 ^ a12;
    if (cmd.early) begin
      ff = reg_r[0] ^ reg_r[1] ^ reg_r[2];
      gg = reg_r[4] ^ reg_r[5] ^ reg_r[6];
    end else begin
      ff = (reg_r[0] & reg_r[1]) | (reg_r[0] & reg_r[2]) | (reg_r[1] & reg_r[2]);
      gg = (reg_r[4] & reg_r[5]) | (~reg_r[4] & reg_r[6]);
    end
    tt1 = ff + reg_r[3] + ss2 + (win_r[0] ^ win_r[4]);
    tt2 = gg + reg_r[7] + ss1 + win_r[0];
    reg_nxt[0] = tt1;
    reg_nxt[1] = reg_r[0];
    reg_nxt[2] = rotl(reg_r[1], 9);
    reg_nxt[3] = reg_r[2];
    reg_nxt[4] = perm0(tt2);
    reg_nxt[5] = reg_r[4];
    reg_nxt[6] = rotl(reg_r[5], 19);
    reg_nxt[7] = reg_r[6];
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= push_word;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= w_exp;
    end

    if (cmd.load) begin
      for (int i = 0; i < 8; i++) begin
        reg_r[i] <= chain_r[i];
      end
      tj_r <= T_LOW;
    end else if (cmd.round) begin
      for (int i = 0; i < 8; i++) begin
        reg_r[i] <= reg_nxt[i];
      end
      // rotl(T, j mod 32) tracked one bit per round
      tj_r <= cmd.t_switch ? rotl(T_HIGH, 16) : rotl(tj_r, 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= SM3_IV[i];
      end
      blen_r <= '0;
    end else begin
      if (cmd.round && cmd.fold) begin
        for (int i = 0; i < 8; i++) begin
          chain_r[i] <= chain_r[i] ^ reg_nxt[i];
        end
      end else if (cmd.out_shift) begin
        // digest leaves from word 0; IV refills from the back
        for (int i = 0; i < 7; i++) begin
          chain_r[i] <= chain_r[i+1];
        end
        chain_r[7] <= SM3_IV[cmd.out_idx];
      end

      if (cmd.clr_len) begin
        blen_r <= '0;
      end else if (cmd.add_len) begin
        blen_r <= blen_r + {58'd0, cnt, 3'b000};
      end
    end
  end

  assign digest_word = chain_r[0];

endmodule

// ===== sv/sm3_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sm3_ctrl import sm3_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  bcount_t in_count,
  input  logic    in_last,
  output logic    in_ready,
  output logic    out_valid,
  output logic    out_last,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_P80   = 6'b000010,
    ST_PADZ  = 6'b000100,
    ST_PADLO = 6'b001000,
    ST_COMP  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  state_t     ret_r, ret_nxt;
  state_t     st_after;
  logic [3:0] idx_r, idx_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] ocnt_r, ocnt_nxt;
  bcount_t    cnt;

  assign cnt = eff_count(in_count, in_last);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    idx_nxt   = idx_r;
    rnd_nxt   = rnd_r;
    ocnt_nxt  = ocnt_r;
    cmd       = '0;
    cmd.sel   = SEL_ZERO;
    cmd.out_idx = ocnt_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_last  = 1'b0;
    st_after  = ST_IDLE;
    if (in_last) begin
      st_after = (cnt == FULL_WORD) ? ST_P80 : ST_PADZ;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.push    = 1'b1;
          cmd.add_len = 1'b1;
          cmd.sel     = (in_last && cnt != FULL_WORD) ? SEL_TAIL : SEL_IN;
          idx_nxt     = idx_r + 4'd1;
          if (idx_r == '1) begin
            cmd.load  = 1'b1;
            ret_nxt   = st_after;
            state_nxt = ST_COMP;
          end else begin
            state_nxt = st_after;
          end
        end
      end
      ST_P80: begin
        cmd.push = 1'b1;
        cmd.sel  = SEL_PAD80;
        idx_nxt  = idx_r + 4'd1;
        if (idx_r == '1) begin
          cmd.load  = 1'b1;
          ret_nxt   = ST_PADZ;
          state_nxt = ST_COMP;
        end else begin
          state_nxt = ST_PADZ;
        end
      end
      ST_PADZ: begin
        cmd.push = 1'b1;
        idx_nxt  = idx_r + 4'd1;
        if (idx_r == 4'd14) begin
          cmd.sel   = SEL_LEN_HI;
          state_nxt = ST_PADLO;
        end else if (idx_r == '1) begin
          // marker took slot 14, no room for the length: zero-fill and run another block
          cmd.load  = 1'b1;
          ret_nxt   = ST_PADZ;
          state_nxt = ST_COMP;
        end
      end
      ST_PADLO: begin
        cmd.push    = 1'b1;
        cmd.sel     = SEL_LEN_LO;
        cmd.clr_len = 1'b1;
        cmd.load    = 1'b1;
        idx_nxt     = idx_r + 4'd1;
        ret_nxt     = ST_OUT;
        state_nxt   = ST_COMP;
      end
      ST_COMP: begin
        cmd.round    = 1'b1;
        cmd.early    = (rnd_r < 6'd16);
        cmd.t_switch = (rnd_r == 6'd15);
        cmd.fold     = (rnd_r == '1);
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == '1) begin
          state_nxt = ret_r;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        out_last  = (ocnt_r == '1);
        if (out_ready) begin
          cmd.out_shift = 1'b1;
          ocnt_nxt      = ocnt_r + 3'd1;
          if (ocnt_r == '1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      idx_r   <= '0;
      rnd_r   <= '0;
      ocnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      idx_r   <= idx_nxt;
      rnd_r   <= rnd_nxt;
      ocnt_r  <= ocnt_nxt;
    end
  end

  `SM3_ASSERT_NEVER(a_no_overlap, clk, rst_n, in_ready && out_valid, "input and output open together")
  `SM3_ASSERT(a_len_lo_slot, clk, rst_n, (cmd.push && cmd.sel == SEL_LEN_LO) |-> (idx_r == '1), "length low word not in last slot")
  `SM3_ASSERT(a_comp_ends, clk, rst_n, (state_r == ST_COMP && rnd_r == '1) |=> (state_r != ST_COMP), "compression overran 64 rounds")
  `SM3_ASSERT(a_msg_done, clk, rst_n, (out_valid && out_ready && out_last) |=> (state_r == ST_IDLE && idx_r == '0), "message not closed after digest")

endmodule
